### hw/rtl/tcsm_pkg.sv
// Package for the TCP connection state machine unit: flag codes, state and outcome
// enums, the transaction and context structs and the sequence-order compare.
// Depends on nothing; every other file of the unit imports it.
package tcsm_pkg;

   localparam int unsigned FLAGS_W = 6;
   localparam int unsigned SEQ_W   = 32;
   localparam int unsigned WIN_W   = 16;
   localparam int unsigned ADDR_W  = 32;
   localparam int unsigned PORT_W  = 16;
   localparam int unsigned STATE_W = 4;

   localparam logic [FLAGS_W-1:0] FLAG_FIN    = 6'd1;
   localparam logic [FLAGS_W-1:0] FLAG_SYN    = 6'd2;
   localparam logic [FLAGS_W-1:0] FLAG_RST    = 6'd4;
   localparam logic [FLAGS_W-1:0] FLAG_ACK    = 6'd16;
   localparam logic [FLAGS_W-1:0] FLAG_SYNACK = 6'd18;
   localparam logic [FLAGS_W-1:0] FLAG_NONE   = 6'd0;

   localparam logic MODE_SEGMENT = 1'b0;
   localparam logic MODE_LOAD    = 1'b1;

   typedef enum logic [STATE_W-1:0] {
      ST_CLOSED     = 4'd0,
      ST_LISTEN     = 4'd1,
      ST_SYN_RECV   = 4'd2,
      ST_SYN_SENT   = 4'd3,
      ST_ESTAB      = 4'd4,
      ST_CLOSE_WAIT = 4'd5,
      ST_LAST_ACK   = 4'd6,
      ST_FIN_WAIT_1 = 4'd7,
      ST_FIN_WAIT_2 = 4'd8,
      ST_CLOSING    = 4'd9,
      ST_TIME_WAIT  = 4'd10
   } conn_state_type;

   typedef enum logic [1:0] {
      OUT_HANDLED       = 2'd0,
      OUT_NO_TRANSITION = 2'd1,
      OUT_BAD_FLAGS     = 2'd2
   } outcome_type;

   typedef struct packed {
      logic               mode;
      logic [FLAGS_W-1:0] seg_flags;
      logic [SEQ_W-1:0]   seg_seq;
      logic [SEQ_W-1:0]   seg_ack;
      logic [WIN_W-1:0]   seg_window;
      logic [ADDR_W-1:0]  src_addr;
      logic [ADDR_W-1:0]  dst_addr;
      logic [PORT_W-1:0]  src_port;
      logic [PORT_W-1:0]  dst_port;
      logic [SEQ_W-1:0]   fresh_isn;
      logic [STATE_W-1:0] load_state;
   } item_type;

   typedef struct packed {
      conn_state_type    conn_state;
      logic [SEQ_W-1:0]  send_next;
      logic [SEQ_W-1:0]  send_unacked;
      logic [SEQ_W-1:0]  recv_next;
      logic [WIN_W-1:0]  send_window;
      logic [SEQ_W-1:0]  initial_seq;
      logic [ADDR_W-1:0] local_addr;
      logic [ADDR_W-1:0] remote_addr;
      logic [PORT_W-1:0] local_port;
      logic [PORT_W-1:0] remote_port;
   } ctx_type;

   typedef struct packed {
      logic               send_control;
      logic [FLAGS_W-1:0] control_flags;
      logic [SEQ_W-1:0]   out_seq;
      logic [SEQ_W-1:0]   out_ack;
      conn_state_type     conn_state_now;
      logic               wake_sender;
      logic               wake_connector;
      logic               conn_accepted;
      logic               start_timewait;
      logic               released;
      outcome_type        outcome;
   } result_type;

   // True when a is at or before b in modulo 2^32 sequence space.
   function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d == '0) || d[SEQ_W-1];
   endfunction

endpackage

### hw/rtl/tcsm_decide.sv
// Combinational decision logic: one transaction against the connection context,
// giving the next context and the result. Depends on tcsm_pkg.
module tcsm_decide
   import tcsm_pkg::*;
(
   input  item_type   item,
   input  ctx_type    ctx,
   output ctx_type    ctx_next,
   output result_type result
);

   logic           is_load;
   logic           is_rst;
   logic           is_syn;
   logic           is_fin;
   logic           is_known;
   logic           win_ok;
   logic [SEQ_W-1:0] seq_plus1;
   conn_state_type load_value;
   conn_state_type state_in;

   assign is_load   = (item.mode == MODE_LOAD);
   assign is_rst    = |(item.seg_flags & FLAG_RST);
   assign is_syn    = |(item.seg_flags & FLAG_SYN);
   assign is_fin    = |(item.seg_flags & FLAG_FIN);
   assign is_known  = |(item.seg_flags & (FLAG_SYN | FLAG_FIN | FLAG_ACK));
   assign win_ok    = seq_le(ctx.send_unacked, item.seg_ack) &&
                      seq_le(item.seg_ack, ctx.send_next);
   assign seq_plus1 = item.seg_seq + SEQ_W'(1);
   assign load_value = (item.load_state > STATE_W'(ST_TIME_WAIT)) ? ST_CLOSED
                       : conn_state_type'(item.load_state);

   always_comb begin
      state_in = ctx.conn_state;
      if (is_load) begin
         state_in = load_value;
      end else if (is_rst) begin
         state_in = ST_CLOSED;
      end else if (is_known) begin
         if (is_syn) begin
            case (ctx.conn_state)
               ST_LISTEN:   state_in = ST_SYN_RECV;
               ST_SYN_SENT: state_in = ST_ESTAB;
               default:     state_in = ctx.conn_state;
            endcase
         end else if (is_fin) begin
            case (ctx.conn_state)
               ST_ESTAB:      state_in = ST_CLOSE_WAIT;
               ST_FIN_WAIT_1: state_in = ST_TIME_WAIT;
               ST_FIN_WAIT_2: state_in = ST_TIME_WAIT;
               default:       state_in = ctx.conn_state;
            endcase
         end else begin
            case (ctx.conn_state)
               ST_SYN_RECV:   state_in = ST_ESTAB;
               ST_FIN_WAIT_1: state_in = ST_FIN_WAIT_2;
               ST_LAST_ACK:   state_in = ST_CLOSED;
               default:       state_in = ctx.conn_state;
            endcase
         end
      end
   end

   always_comb begin
      ctx_next            = ctx;
      ctx_next.conn_state = state_in;
      result              = '0;
      result.outcome      = OUT_HANDLED;
      if (is_load) begin
         ctx_next.send_next    = item.seg_seq;
         ctx_next.send_unacked = item.seg_ack;
      end else if (is_rst) begin
         result.released = 1'b1;
      end else if (is_known) begin
         if (win_ok) begin
            ctx_next.send_window = item.seg_window;
            result.wake_sender   = (ctx.send_window == '0);
         end
         if (is_syn) begin
            case (ctx.conn_state)
               ST_LISTEN: begin
                  ctx_next.local_addr  = item.dst_addr;
                  ctx_next.remote_addr = item.src_addr;
                  ctx_next.local_port  = item.dst_port;
                  ctx_next.remote_port = item.src_port;
                  ctx_next.initial_seq = item.fresh_isn;
                  ctx_next.send_next   = item.fresh_isn;
                  ctx_next.recv_next   = seq_plus1;
                  result.control_flags = FLAG_SYNACK;
               end
               ST_SYN_SENT: begin
                  ctx_next.send_next    = item.seg_ack;
                  ctx_next.recv_next    = seq_plus1;
                  result.control_flags  = FLAG_ACK;
                  result.wake_connector = 1'b1;
               end
               default: result.outcome = OUT_NO_TRANSITION;
            endcase
         end else if (is_fin) begin
            case (ctx.conn_state)
               ST_ESTAB: begin
                  ctx_next.local_addr  = item.dst_addr;
                  ctx_next.remote_addr = item.src_addr;
                  ctx_next.local_port  = item.dst_port;
                  ctx_next.remote_port = item.src_port;
                  ctx_next.recv_next   = seq_plus1;
                  ctx_next.send_next   = ctx.send_next + SEQ_W'(1);
                  result.control_flags = FLAG_ACK;
               end
               ST_FIN_WAIT_1, ST_FIN_WAIT_2: begin
                  ctx_next.local_addr   = item.dst_addr;
                  ctx_next.remote_addr  = item.src_addr;
                  ctx_next.local_port   = item.dst_port;
                  ctx_next.remote_port  = item.src_port;
                  ctx_next.send_next    = item.seg_ack;
                  ctx_next.recv_next    = seq_plus1;
                  result.control_flags  = FLAG_ACK;
                  result.start_timewait = 1'b1;
               end
               default: result.outcome = OUT_NO_TRANSITION;
            endcase
         end else begin
            case (ctx.conn_state)
               ST_SYN_RECV:   result.conn_accepted = 1'b1;
               ST_FIN_WAIT_1: result.outcome = OUT_HANDLED;
               ST_LAST_ACK:   result.outcome = OUT_HANDLED;
               default:       result.outcome = OUT_NO_TRANSITION;
            endcase
         end
      end else begin
         result.outcome = OUT_BAD_FLAGS;
      end
      result.send_control   = (result.control_flags != FLAG_NONE);
      result.out_seq        = ctx_next.send_next;
      result.out_ack        = ctx_next.recv_next;
      result.conn_state_now = state_in;
   end

endmodule

### hw/rtl/tcp_connection_state_machine_unit.sv
// Top level of the TCP connection state machine unit: input register, connection
// context registers and result register around tcsm_decide. Depends on tcsm_pkg and tcsm_decide.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid / req_ready  segment header or load transaction
//   rsp_     out        rsp_valid / rsp_ready  control request, pointers, state, events
//
// One transaction per cycle is sustained while rsp_ready stays high.
// The decision is taken as a transaction moves from the input register to the result
// register, which is also when the connection context is updated.
// A stalled result holds its register; the input register still fills behind it.
// Synchronous active-high reset closes the connection and clears all pointers.
module tcp_connection_state_machine_unit
   import tcsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [FLAGS_W-1:0] req_seg_flags,
   input  logic [SEQ_W-1:0]   req_seg_seq,
   input  logic [SEQ_W-1:0]   req_seg_ack,
   input  logic [WIN_W-1:0]   req_seg_window,
   input  logic [ADDR_W-1:0]  req_src_addr,
   input  logic [ADDR_W-1:0]  req_dst_addr,
   input  logic [PORT_W-1:0]  req_src_port,
   input  logic [PORT_W-1:0]  req_dst_port,
   input  logic [SEQ_W-1:0]   req_fresh_isn,
   input  logic [STATE_W-1:0] req_load_state,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_send_control,
   output logic [FLAGS_W-1:0] rsp_control_flags,
   output logic [SEQ_W-1:0]   rsp_out_seq,
   output logic [SEQ_W-1:0]   rsp_out_ack,
   output logic [STATE_W-1:0] rsp_conn_state_now,
   output logic               rsp_wake_sender,
   output logic               rsp_wake_connector,
   output logic               rsp_conn_accepted,
   output logic               rsp_start_timewait,
   output logic               rsp_released,
   output logic [1:0]         rsp_outcome
);

   item_type   item_ff;
   item_type   item_in;
   logic       item_valid_ff;
   ctx_type    ctx_ff;
   ctx_type    ctx_in;
   result_type result_ff;
   result_type result_in;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_fire;

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign item_in = '{
      mode:       req_mode,
      seg_flags:  req_seg_flags,
      seg_seq:    req_seg_seq,
      seg_ack:    req_seg_ack,
      seg_window: req_seg_window,
      src_addr:   req_src_addr,
      dst_addr:   req_dst_addr,
      src_port:   req_src_port,
      dst_port:   req_dst_port,
      fresh_isn:  req_fresh_isn,
      load_state: req_load_state
   };

   tcsm_decide u_decide (
      .item     (item_ff),
      .ctx      (ctx_ff),
      .ctx_next (ctx_in),
      .result   (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ctx_ff        <= '0;
      end else begin
         if (req_fire) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            ctx_ff       <= ctx_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_control   = result_ff.send_control;
   assign rsp_control_flags  = result_ff.control_flags;
   assign rsp_out_seq        = result_ff.out_seq;
   assign rsp_out_ack        = result_ff.out_ack;
   assign rsp_conn_state_now = result_ff.conn_state_now;
   assign rsp_wake_sender    = result_ff.wake_sender;
   assign rsp_wake_connector = result_ff.wake_connector;
   assign rsp_conn_accepted  = result_ff.conn_accepted;
   assign rsp_start_timewait = result_ff.start_timewait;
   assign rsp_released       = result_ff.released;
   assign rsp_outcome        = result_ff.outcome;

   a_release_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_released |-> rsp_conn_state_now == ST_CLOSED && !rsp_send_control)
      else $error("release did not leave the connection closed");

   a_control_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_send_control && (rsp_control_flags == FLAG_ACK ||
                                          rsp_control_flags == FLAG_SYNACK)) ||
                    (!rsp_send_control && rsp_control_flags == FLAG_NONE))
      else $error("control flags disagree with send_control");

   a_connector_estab: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_wake_connector || rsp_conn_accepted) |->
         rsp_conn_state_now == ST_ESTAB)
      else $error("open completion without ESTABLISHED state");

   a_timewait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_start_timewait |-> rsp_conn_state_now == ST_TIME_WAIT &&
         rsp_out_seq == ctx_ff.send_next)
      else $error("time-wait start without TIME_WAIT state");

   a_state_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_conn_state_now == ctx_ff.conn_state)
      else $error("reported state diverged from the context");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_ready)
      else $error("input register empty but not ready");

endmodule

### test/tcp_connection_state_machine_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for tcp_connection_state_machine_unit: a response checker class predicts every
// response from its own copy of the connection context, and plain tasks drive the block.
// Depends on tcsm_pkg and the RTL of tcp_connection_state_machine_unit only.
module tcp_connection_state_machine_unit_tb;
   import tcsm_pkg::*;

   localparam logic [FLAGS_W-1:0] FLAG_PSH = 6'd8;
   localparam logic [FLAGS_W-1:0] FLAG_URG = 6'd32;
   localparam int unsigned ITEMS       = 1850;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned TAIL_CYCLES = 8;

   class response_checker;
      ctx_type     ctx;
      result_type  expected_q[$];
      int unsigned mismatches;
      int unsigned responses;

      function new();
         ctx = '0;
         mismatches = 0;
         responses = 0;
      endfunction

      function int unsigned outstanding();
         return expected_q.size();
      endfunction

      function logic not_after(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
         logic [SEQ_W-1:0] gap;
         gap = b - a;
         return gap <= 32'h8000_0000;
      endfunction

      function void keep_tuple(input item_type it);
         ctx.local_addr = it.dst_addr;
         ctx.remote_addr = it.src_addr;
         ctx.local_port = it.dst_port;
         ctx.remote_port = it.src_port;
      endfunction

      function result_type predict_response(input item_type it);
         result_type         r;
         logic [FLAGS_W-1:0] ctl;
         r = '0;
         ctl = FLAG_NONE;
         r.outcome = OUT_HANDLED;
         if (it.mode == MODE_LOAD) begin
            ctx.conn_state = (it.load_state > ST_TIME_WAIT) ? ST_CLOSED
                                                           : conn_state_type'(it.load_state);
            ctx.send_next = it.seg_seq;
            ctx.send_unacked = it.seg_ack;
         end else if ((it.seg_flags & FLAG_RST) != FLAG_NONE) begin
            ctx.conn_state = ST_CLOSED;
            r.released = 1'b1;
         end else if ((it.seg_flags & (FLAG_SYN | FLAG_FIN | FLAG_ACK)) != FLAG_NONE) begin
            if (not_after(ctx.send_unacked, it.seg_ack) && not_after(it.seg_ack, ctx.send_next)) begin
               r.wake_sender = (ctx.send_window == '0);
               ctx.send_window = it.seg_window;
            end
            if ((it.seg_flags & FLAG_SYN) != FLAG_NONE) begin
               case (ctx.conn_state)
                  ST_LISTEN: begin
                     ctx.conn_state = ST_SYN_RECV;
                     keep_tuple(it);
                     ctx.initial_seq = it.fresh_isn;
                     ctx.send_next = it.fresh_isn;
                     ctx.recv_next = it.seg_seq + 32'd1;
                     ctl = FLAG_SYNACK;
                  end
                  ST_SYN_SENT: begin
                     ctx.conn_state = ST_ESTAB;
                     ctx.send_next = it.seg_ack;
                     ctx.recv_next = it.seg_seq + 32'd1;
                     ctl = FLAG_ACK;
                     r.wake_connector = 1'b1;
                  end
                  default: r.outcome = OUT_NO_TRANSITION;
               endcase
            end else if ((it.seg_flags & FLAG_FIN) != FLAG_NONE) begin
               case (ctx.conn_state)
                  ST_ESTAB: begin
                     keep_tuple(it);
                     ctx.recv_next = it.seg_seq + 32'd1;
                     ctx.send_next = ctx.send_next + 32'd1;
                     ctx.conn_state = ST_CLOSE_WAIT;
                     ctl = FLAG_ACK;
                  end
                  ST_FIN_WAIT_1, ST_FIN_WAIT_2: begin
                     ctx.conn_state = ST_TIME_WAIT;
                     keep_tuple(it);
                     ctx.send_next = it.seg_ack;
                     ctx.recv_next = it.seg_seq + 32'd1;
                     r.start_timewait = 1'b1;
                     ctl = FLAG_ACK;
                  end
                  default: r.outcome = OUT_NO_TRANSITION;
               endcase
            end else begin
               case (ctx.conn_state)
                  ST_SYN_RECV: begin
                     ctx.conn_state = ST_ESTAB;
                     r.conn_accepted = 1'b1;
                  end
                  ST_FIN_WAIT_1: ctx.conn_state = ST_FIN_WAIT_2;
                  ST_LAST_ACK: ctx.conn_state = ST_CLOSED;
                  default: r.outcome = OUT_NO_TRANSITION;
               endcase
            end
         end else begin
            r.outcome = OUT_BAD_FLAGS;
         end
         r.send_control = (ctl != FLAG_NONE);
         r.control_flags = ctl;
         r.out_seq = ctx.send_next;
         r.out_ack = ctx.recv_next;
         r.conn_state_now = ctx.conn_state;
         return r;
      endfunction

      function void note_request(input item_type it);
         expected_q.push_back(predict_response(it));
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         mismatches++;
         if (mismatches <= 40)
            $display("[%0t] response %0d: %s is %h, expected %h", $time, responses, what, got,
                     want);
      endtask

      task check_response(input result_type got);
         result_type want;
         responses++;
         if (expected_q.size() == 0) begin
            report("response with no transaction waiting", 32'd0, 32'd0);
         end else begin
            want = expected_q.pop_front();
            if (got.send_control !== want.send_control)
               report("send_control", got.send_control, want.send_control);
            if (got.control_flags !== want.control_flags)
               report("control_flags", got.control_flags, want.control_flags);
            if (got.out_seq !== want.out_seq)
               report("out_seq", got.out_seq, want.out_seq);
            if (got.out_ack !== want.out_ack)
               report("out_ack", got.out_ack, want.out_ack);
            if (got.conn_state_now !== want.conn_state_now)
               report("conn_state_now", got.conn_state_now, want.conn_state_now);
            if (got.wake_sender !== want.wake_sender)
               report("wake_sender", got.wake_sender, want.wake_sender);
            if (got.wake_connector !== want.wake_connector)
               report("wake_connector", got.wake_connector, want.wake_connector);
            if (got.conn_accepted !== want.conn_accepted)
               report("conn_accepted", got.conn_accepted, want.conn_accepted);
            if (got.start_timewait !== want.start_timewait)
               report("start_timewait", got.start_timewait, want.start_timewait);
            if (got.released !== want.released)
               report("released", got.released, want.released);
            if (got.outcome !== want.outcome)
               report("outcome", got.outcome, want.outcome);
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_mode;
   logic [FLAGS_W-1:0] req_seg_flags;
   logic [SEQ_W-1:0]   req_seg_seq;
   logic [SEQ_W-1:0]   req_seg_ack;
   logic [WIN_W-1:0]   req_seg_window;
   logic [ADDR_W-1:0]  req_src_addr;
   logic [ADDR_W-1:0]  req_dst_addr;
   logic [PORT_W-1:0]  req_src_port;
   logic [PORT_W-1:0]  req_dst_port;
   logic [SEQ_W-1:0]   req_fresh_isn;
   logic [STATE_W-1:0] req_load_state;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_send_control;
   logic [FLAGS_W-1:0] rsp_control_flags;
   logic [SEQ_W-1:0]   rsp_out_seq;
   logic [SEQ_W-1:0]   rsp_out_ack;
   logic [STATE_W-1:0] rsp_conn_state_now;
   logic               rsp_wake_sender;
   logic               rsp_wake_connector;
   logic               rsp_conn_accepted;
   logic               rsp_start_timewait;
   logic               rsp_released;
   logic [1:0]         rsp_outcome;

   response_checker conn_check;
   int unsigned     burst_left = 0;
   int unsigned     items_sent = 0;
   int unsigned     quiet_cycles = 0;
   logic [SEQ_W-1:0] g_una;
   logic [SEQ_W-1:0] g_nxt;
   logic            hold_ask = 1'b0;
   logic            hold_served = 1'b0;

   tcp_connection_state_machine_unit u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin : monitor
      item_type   taken;
      result_type seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            taken = {req_mode, req_seg_flags, req_seg_seq, req_seg_ack, req_seg_window,
                     req_src_addr, req_dst_addr, req_src_port, req_dst_port, req_fresh_isn,
                     req_load_state};
            conn_check.note_request(taken);
         end
         if (rsp_valid && rsp_ready) begin
            seen.send_control = rsp_send_control;
            seen.control_flags = rsp_control_flags;
            seen.out_seq = rsp_out_seq;
            seen.out_ack = rsp_out_ack;
            seen.conn_state_now = conn_state_type'(rsp_conn_state_now);
            seen.wake_sender = rsp_wake_sender;
            seen.wake_connector = rsp_wake_connector;
            seen.conn_accepted = rsp_conn_accepted;
            seen.start_timewait = rsp_start_timewait;
            seen.released = rsp_released;
            seen.outcome = outcome_type'(rsp_outcome);
            conn_check.check_response(seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("** tcp_connection_state_machine_unit: FAILED **");
      $finish;
   end

   initial begin : response_pacer
      int unsigned tick;
      int unsigned stall_run;
      logic        grant;
      tick = 0;
      stall_run = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_served) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end
         tick++;
         case ((tick / 400) % 4)
            0: grant = 1'b1;
            1: grant = 1'($urandom_range(0, 1));
            2: grant = ($urandom_range(0, 3) == 0);
            default: begin
               if (stall_run > 0) begin
                  stall_run--;
                  grant = 1'b0;
               end else if ($urandom_range(0, 9) == 0) begin
                  stall_run = $urandom_range(1, 15);
                  grant = 1'b0;
               end else begin
                  grant = 1'b1;
               end
            end
         endcase
         rsp_ready <= reset ? 1'b0 : grant;
      end
   end

   function automatic logic [FLAGS_W-1:0] extra_bits();
      return ($urandom_range(0, 1) ? FLAG_PSH : FLAG_NONE) |
             ($urandom_range(0, 1) ? FLAG_URG : FLAG_NONE);
   endfunction

   function automatic logic [SEQ_W-1:0] pick_seq();
      if ($urandom_range(0, 7) == 0)
         return 32'hFFFF_FFFF - $urandom_range(0, 2);
      return $urandom;
   endfunction

   function automatic logic [SEQ_W-1:0] pick_ack();
      logic [SEQ_W-1:0] span;
      span = g_nxt - g_una;
      case ($urandom_range(0, 5))
         0: return g_una;
         1: return g_nxt;
         2: return g_nxt + 32'd1;
         3: return $urandom;
         default: return span[SEQ_W-1] ? g_una : g_una + ($urandom % (span + 32'd1));
      endcase
   endfunction

   function automatic logic [WIN_W-1:0] pick_window();
      case ($urandom_range(0, 7))
         0, 1: return '0;
         2: return '1;
         default: return WIN_W'($urandom);
      endcase
   endfunction

   function automatic item_type make_segment(input logic [FLAGS_W-1:0] flags,
                                             input logic [SEQ_W-1:0] seq,
                                             input logic [SEQ_W-1:0] ack,
                                             input logic [WIN_W-1:0] win);
      item_type it;
      it.mode = MODE_SEGMENT;
      it.seg_flags = flags;
      it.seg_seq = seq;
      it.seg_ack = ack;
      it.seg_window = win;
      it.src_addr = $urandom;
      it.dst_addr = $urandom;
      it.src_port = PORT_W'($urandom);
      it.dst_port = PORT_W'($urandom);
      it.fresh_isn = $urandom;
      it.load_state = STATE_W'($urandom);
      return it;
   endfunction

   function automatic item_type make_load(input logic [STATE_W-1:0] st,
                                          input logic [SEQ_W-1:0] nxt,
                                          input logic [SEQ_W-1:0] una);
      item_type it;
      it = make_segment(FLAGS_W'($urandom), nxt, una, WIN_W'($urandom));
      it.mode = MODE_LOAD;
      it.load_state = st;
      return it;
   endfunction

   function automatic item_type noise_item();
      item_type it;
      it = make_segment(FLAGS_W'($urandom), pick_seq(), pick_ack(), pick_window());
      it.mode = ($urandom_range(0, 3) == 0) ? MODE_LOAD : MODE_SEGMENT;
      return it;
   endfunction

   task automatic send_item(input item_type it);
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_seg_flags <= it.seg_flags;
      req_seg_seq <= it.seg_seq;
      req_seg_ack <= it.seg_ack;
      req_seg_window <= it.seg_window;
      req_src_addr <= it.src_addr;
      req_dst_addr <= it.dst_addr;
      req_src_port <= it.src_port;
      req_dst_port <= it.dst_port;
      req_fresh_isn <= it.fresh_isn;
      req_load_state <= it.load_state;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_paced(input item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      send_item(it);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (conn_check.outstanding() != 0);
      @(posedge clock);
      burst_left = 0;
   endtask

   // Occasionally a reset or a stray transaction breaks into the sequence.
   task automatic flow_send(input item_type it);
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (roll == 0)
         send_paced(make_segment(FLAG_RST | extra_bits(), pick_seq(), pick_ack(), pick_window()));
      else if (roll == 1)
         send_paced(noise_item());
      send_paced(it);
   endtask

   task automatic data_acks();
      int unsigned n;
      n = $urandom_range(0, 5);
      repeat (n) flow_send(make_segment(FLAG_ACK | extra_bits(), pick_seq(), pick_ack(),
                                        pick_window()));
   endtask

   task automatic run_flow();
      item_type           it;
      logic [FLAGS_W-1:0] f;
      logic [STATE_W-1:0] st;
      int unsigned        n;
      g_una = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000) : $urandom;
      g_nxt = g_una + $urandom_range(0, 5000);
      case ($urandom_range(0, 3))
         0: begin
            flow_send(make_load(ST_LISTEN, g_nxt, g_una));
            it = make_segment(($urandom_range(0, 1) ? FLAG_SYN : FLAG_SYNACK) | extra_bits(),
                              pick_seq(), pick_ack(), pick_window());
            it.fresh_isn = g_una + $urandom_range(0, 3000);
            g_nxt = it.fresh_isn;
            flow_send(it);
            flow_send(make_segment(FLAG_ACK | extra_bits(), pick_seq(), pick_ack(),
                                   pick_window()));
            data_acks();
            flow_send(make_segment(FLAG_FIN | ($urandom_range(0, 1) ? FLAG_ACK : FLAG_NONE),
                                   pick_seq(), pick_ack(), pick_window()));
            g_nxt = g_nxt + 32'd1;
            flow_send(make_load(ST_LAST_ACK, g_nxt, g_una));
            flow_send(make_segment(FLAG_ACK, pick_seq(), pick_ack(), pick_window()));
         end
         1: begin
            flow_send(make_load(ST_SYN_SENT, g_nxt, g_una));
            it = make_segment(FLAG_SYNACK | extra_bits(), pick_seq(), pick_ack(), pick_window());
            g_nxt = it.seg_ack;
            flow_send(it);
            data_acks();
            g_nxt = g_nxt + 32'd1;
            flow_send(make_load(ST_FIN_WAIT_1, g_nxt, g_una));
            if ($urandom_range(0, 1))
               flow_send(make_segment(FLAG_ACK, pick_seq(), pick_ack(), pick_window()));
            flow_send(make_segment(FLAG_FIN | ($urandom_range(0, 1) ? FLAG_ACK : FLAG_NONE),
                                   pick_seq(), pick_ack(), pick_window()));
         end
         2: begin
            st = ($urandom_range(0, 5) == 0) ? STATE_W'($urandom_range(11, 15))
                                             : STATE_W'($urandom_range(0, 10));
            flow_send(make_load(st, g_nxt, g_una));
            n = $urandom_range(1, 6);
            repeat (n) begin
               case ($urandom_range(0, 6))
                  0: f = FLAG_SYN;
                  1: f = FLAG_FIN;
                  2: f = FLAG_ACK;
                  3: f = FLAG_SYNACK;
                  4: f = FLAG_FIN | FLAG_ACK;
                  5: f = FLAG_RST;
                  default: f = FLAG_NONE;
               endcase
               flow_send(make_segment(f | extra_bits(), pick_seq(), pick_ack(), pick_window()));
            end
         end
         default: begin
            flow_send(make_load(ST_ESTAB, g_nxt, g_una));
            data_acks();
            flow_send(make_segment(FLAG_FIN | FLAG_ACK, pick_seq(), pick_ack(), pick_window()));
            g_nxt = g_nxt + 32'd1;
            data_acks();
         end
      endcase
   endtask

   task automatic run_directed();
      item_type it;
      send_paced(make_segment(FLAG_NONE, '0, '0, '0));
      send_paced(make_segment(FLAG_PSH | FLAG_URG, '1, '1, '1));
      send_paced(make_segment('1, '1, '1, '1));
      send_paced(make_segment(FLAG_ACK, '0, '0, '1));
      send_paced(make_load(ST_LISTEN, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
      it = make_segment(FLAG_SYN, 32'hFFFF_FFFF, 32'hFFFF_FFF8, '0);
      it.fresh_isn = '0;
      it.src_addr = '1;
      it.dst_addr = '1;
      it.src_port = '1;
      it.dst_port = '1;
      send_paced(it);
      send_paced(make_segment(FLAG_SYN, 32'd5, 32'd0, 16'd7));
      send_paced(make_segment(FLAG_FIN, 32'd5, 32'h7000_0000, 16'd7));
      send_paced(make_segment(FLAG_ACK, 32'd1, 32'd0, 16'h1234));
      send_paced(make_segment(FLAG_ACK, 32'd1, 32'h7000_0000, '0));
      it = make_segment(FLAG_FIN | FLAG_ACK, 32'h8000_0000, 32'd0, '0);
      it.src_addr = '0;
      it.dst_addr = '0;
      it.src_port = '0;
      it.dst_port = '0;
      send_paced(it);
      send_paced(make_segment(FLAG_FIN, 32'd9, 32'd1, 16'd3));
      send_paced(make_load(ST_LAST_ACK, 32'd100, 32'd50));
      send_paced(make_segment(FLAG_ACK, 32'd1, 32'd75, 16'd100));
      send_paced(make_load(ST_SYN_SENT, 32'd1000, 32'd1000));
      send_paced(make_segment(FLAG_SYNACK, 32'd4000, 32'd1000, 16'd500));
      send_paced(make_load(ST_FIN_WAIT_1, 32'd2000, 32'd1000));
      send_paced(make_segment(FLAG_ACK, 32'd4001, 32'd1500, '0));
      send_paced(make_segment(FLAG_FIN, 32'd4001, 32'd2000, 16'd9));
      send_paced(make_load(ST_FIN_WAIT_1, 32'd3000, 32'd3000));
      send_paced(make_segment(FLAG_FIN | FLAG_ACK, 32'd77, 32'd3000, 16'd1));
      send_paced(make_load(4'd15, '1, '1));
      send_paced(make_load(ST_CLOSING, '0, '0));
      send_paced(make_segment(FLAG_ACK, '0, '0, 16'd2));
      send_paced(make_load(ST_ESTAB, '1, '0));
      send_paced(make_segment(FLAG_RST | FLAG_SYN, '1, '1, '1));
   endtask

   initial begin : stimulus
      logic paused_once;
      paused_once = 1'b0;
      conn_check = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_SEGMENT;
      req_seg_flags = FLAG_NONE;
      req_seg_seq = '0;
      req_seg_ack = '0;
      req_seg_window = '0;
      req_src_addr = '0;
      req_dst_addr = '0;
      req_src_port = '0;
      req_dst_port = '0;
      req_fresh_isn = '0;
      req_load_state = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      drain();
      while (items_sent < ITEMS) begin
         if (!hold_ask && items_sent >= 600)
            hold_ask = 1'b1;
         if (!paused_once && items_sent >= 1200) begin
            drain();
            paused_once = 1'b1;
         end
         if ($urandom_range(0, 9) < 7)
            run_flow();
         else
            send_paced(noise_item());
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (conn_check.mismatches == 0 && conn_check.outstanding() == 0)
         $display("** tcp_connection_state_machine_unit: PASSED **");
      else
         $display("** tcp_connection_state_machine_unit: FAILED **");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/tcsm_pkg.sv
hw/rtl/tcsm_decide.sv
hw/rtl/tcp_connection_state_machine_unit.sv
test/tcp_connection_state_machine_unit_tb.sv
